@@ rtl/core/ordered_dither_halftone_block_defines.svh @@
// Assertion macros for the halftone block's checker file, odh_checker.
// Depends on: nothing; expects aclk and aresetn in the scope of use.
`ifndef ORDERED_DITHER_HALFTONE_BLOCK_DEFINES_SVH
`define ORDERED_DITHER_HALFTONE_BLOCK_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define ODH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while in reset.
`define ODH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define ODH_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/odh_pkg.sv @@
// Package for the ordered dither halftone block: payload types and constants.
// Depends on: nothing.
package odh_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int PIX_W       = 8;
    localparam int LEVEL_W     = 4;
    localparam int MASK_W      = 9;
    localparam int MAT_SIDE    = 3;

    // item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // level quantizer for m = 3: divisor 28, reciprocal 73 / 2048 (underestimates by < 1)
    localparam logic [4:0] DIV3      = 5'd28;
    localparam logic [6:0] RECIP3    = 7'd73;
    localparam int         RECIP3_SH = 11;

    // clustered-dot thresholds, index row*3+col
    localparam logic [LEVEL_W-1:0] THRESH [MASK_W] = '{
        4'd6, 4'd8, 4'd4,
        4'd1, 4'd0, 4'd3,
        4'd5, 4'd2, 4'd7
    };

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] table_index;
        logic [PIX_W-1:0] table_value;
        logic [PIX_W-1:0] pixel;
    } odh_in_t;

    typedef struct packed {
        logic [MASK_W-1:0]  dot_mask;
        logic [LEVEL_W-1:0] level;
    } odh_out_t;

endpackage

@@ rtl/core/odh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on: nothing.
module odh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ordered_dither_halftone_block.sv @@
// Top level of the clustered-dot ordered dither halftone block.
// Depends on: odh_pkg, odh_ram.
//
// Usage:
//   s_valid/s_ready/s_data carry input transactions. op = load writes
//   table_value into gamma table entry table_index and yields no result;
//   op = pixel looks the pixel up in the table, quantizes it to a level and
//   yields one m_data transaction: dot_mask (bit row*3+col white) and level.
//   Load the whole table before sending pixels.
//   cfg_we/cfg_wdata set block_size m (0 acts as 1, above MAX_BLOCK is
//   clamped); write it only while the block is idle.
// Pipeline:
//   One transaction per cycle unless m_ready stalls the output. The accepting
//   edge does the table read; reciprocal multiply, quotient correction and level
//   select, and threshold compare follow, each into its own register.
// Reset:
//   aresetn clears all pipeline valid bits and sets block_size to 3.
//   The gamma table is not cleared.
// Stall:
//   Low m_ready holds the output; the stages behind it fill up and s_ready
//   falls only when every stage holds a pixel. Nothing is lost or repeated.
module ordered_dither_halftone_block #(
    parameter int MAX_BLOCK = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  odh_pkg::odh_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output odh_pkg::odh_out_t m_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_wdata
);

    localparam int PW = odh_pkg::PIX_W;
    localparam int LW = odh_pkg::LEVEL_W;
    localparam int MW = odh_pkg::MASK_W;
    localparam int PROD_W = PW + 7;

    logic [1:0] block_size_reg, block_size_next;
    logic [1:0] m_eff;

    logic          v1_reg, v1_next;
    logic [1:0]    m1_reg;
    logic [PW-1:0] gamma;

    logic          v2_reg, v2_next;
    logic [1:0]    m2_reg;
    logic [PW-1:0] g2_reg;
    logic [LW-1:0] q2_reg, q2_next;
    logic [PROD_W-1:0] prod;

    logic          v3_reg, v3_next;
    logic [1:0]    m3_reg;
    logic [LW-1:0] lvl3_reg, lvl3_next;
    logic [PW-1:0] rem;
    logic [LW-1:0] q_fix;

    logic              out_valid_reg, out_valid_next;
    odh_pkg::odh_out_t out_reg, out_next;

    logic load1, load2, load3, load4;
    logic s_accept;

    // ---------------- configuration ----------------
    always_comb begin
        block_size_next = cfg_we ? cfg_wdata : block_size_reg;
        if (block_size_reg == 2'd0) begin
            m_eff = 2'd1;
        end else if (block_size_reg > 2'(MAX_BLOCK)) begin
            m_eff = 2'(MAX_BLOCK);
        end else begin
            m_eff = block_size_reg;
        end
    end

    // ---------------- pipeline flow control ----------------
    assign load4    = !out_valid_reg || m_ready;
    assign load3    = !v3_reg || load4;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign s_ready  = load1;
    assign s_accept = s_valid && s_ready;

    // ---------------- stage 1: table read ----------------
    odh_ram #(
        .WIDTH(PW),
        .DEPTH(odh_pkg::TABLE_DEPTH)
    ) u_gamma (
        .aclk (aclk),
        .we   (s_accept && (s_data.op == odh_pkg::OP_LOAD)),
        .waddr(s_data.table_index),
        .wdata(s_data.table_value),
        .re   (s_accept && (s_data.op == odh_pkg::OP_PIXEL)),
        .raddr(s_data.pixel),
        .rdata(gamma)
    );

    assign v1_next = load1 ? (s_accept && (s_data.op == odh_pkg::OP_PIXEL)) : v1_reg;

    // ---------------- stage 2: reciprocal estimate ----------------
    assign prod    = PROD_W'(gamma) * PROD_W'(odh_pkg::RECIP3);
    assign q2_next = prod[PROD_W-1 -: LW];
    assign v2_next = load2 ? v1_reg : v2_reg;

    // ---------------- stage 3: correct quotient, select level ----------------
    always_comb begin
        rem   = g2_reg - PW'(q2_reg * odh_pkg::DIV3);
        q_fix = (rem >= PW'(odh_pkg::DIV3)) ? q2_reg + LW'(1) : q2_reg;
        case (m2_reg)
            2'd2:    lvl3_next = LW'(g2_reg[PW-1 -: 2]);
            2'd3:    lvl3_next = q_fix;
            default: lvl3_next = '0;
        endcase
    end
    assign v3_next = load3 ? v2_reg : v3_reg;

    // ---------------- stage 4: threshold compare ----------------
    always_comb begin
        out_next.level = lvl3_reg;
        for (int i = 0; i < MW; i++) begin
            out_next.dot_mask[i] = ((i / odh_pkg::MAT_SIDE) < int'(m3_reg))
                                && ((i % odh_pkg::MAT_SIDE) < int'(m3_reg))
                                && (lvl3_reg > odh_pkg::THRESH[i]);
        end
    end
    assign out_valid_next = load4 ? v3_reg : out_valid_reg;

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= 2'd3;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            block_size_reg <= block_size_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            v3_reg         <= v3_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            m1_reg <= m_eff;
        end
        if (load2) begin
            m2_reg <= m1_reg;
            g2_reg <= gamma;
            q2_reg <= q2_next;
        end
        if (load3) begin
            m3_reg   <= m2_reg;
            lvl3_reg <= lvl3_next;
        end
        if (load4) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ rtl/core/odh_checker.sv @@
// Port-level checker for the ordered dither halftone block, bound to the top.
// Depends on: odh_pkg, ordered_dither_halftone_block_defines.svh.
`include "ordered_dither_halftone_block_defines.svh"

module odh_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input odh_pkg::odh_out_t m_data
);

    `ODH_ASSERT_RST(a_rst_clears_out, !aresetn, !m_valid, "result valid right after reset")

    `ODH_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")

    `ODH_ASSERT_IMPL(a_level_range, m_valid, m_data.level <= 4'd9, "level above nine")

    `ODH_ASSERT_IMPL(a_dark_empty, m_valid && (m_data.level == 4'd0), m_data.dot_mask == 9'd0, "dot set at level zero")

    `ODH_ASSERT_IMPL(a_center_dot, m_valid && (m_data.level >= 4'd4), m_data.dot_mask[4], "center dot missing")

endmodule

bind ordered_dither_halftone_block odh_checker u_odh_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for ordered_dither_halftone_block: a directed table at reset
// block size, then random phases over every block size, checked by an in-bench predictor.
// Depends on: odh_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_BLOCK   = 3;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 316;
    localparam int SETTLE_MAX  = 2000;
    localparam int PIPE_TAIL   = 8;
    localparam int HOLD_CYCLES = 80;

    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;

    // clustered-dot thresholds, row-major
    localparam logic [3:0] DOT_ORDER [9] = '{
        4'd6, 4'd8, 4'd4,
        4'd1, 4'd0, 4'd3,
        4'd5, 4'd2, 4'd7
    };

    // block size per random phase; 0 acts as 1
    localparam logic [1:0] PHASE_SIZE [NUM_PHASES] = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd3};

    typedef struct packed {
        odh_pkg::odh_in_t  item;
        logic              typed;
        odh_pkg::odh_out_t want;
    } plan_row_t;

    // op, table_index, table_value, pixel, typed, dot_mask, level (block size 3)
    localparam plan_row_t PLAN [21] = '{
        {odh_pkg::OP_LOAD,  8'd0,   8'd0,   8'd0,   PRED,  9'h000, 4'd0},
        {odh_pkg::OP_LOAD,  8'd255, 8'd255, 8'd0,   PRED,  9'h000, 4'd0},
        {odh_pkg::OP_LOAD,  8'd128, 8'd28,  8'd0,   PRED,  9'h000, 4'd0},
        {odh_pkg::OP_LOAD,  8'd1,   8'd27,  8'd0,   PRED,  9'h000, 4'd0},
        {odh_pkg::OP_LOAD,  8'd2,   8'd251, 8'd0,   PRED,  9'h000, 4'd0},
        {odh_pkg::OP_LOAD,  8'd3,   8'd252, 8'd0,   PRED,  9'h000, 4'd0},
        {odh_pkg::OP_LOAD,  8'd4,   8'd85,  8'd255, PRED,  9'h000, 4'd0}, // pixel ignored
        {odh_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd0,   TYPED, 9'h000, 4'd0},
        {odh_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd255, TYPED, 9'h1FF, 4'd9},
        {odh_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd128, TYPED, 9'h010, 4'd1},
        {odh_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd1,   TYPED, 9'h000, 4'd0},
        {odh_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd2,   TYPED, 9'h1FD, 4'd8},
        {odh_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd3,   TYPED, 9'h1FF, 4'd9},
        {odh_pkg::OP_PIXEL, 8'hAA,  8'hFF,  8'd0,   TYPED, 9'h000, 4'd0}, // table fields ignored
        {odh_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd4,   PRED,  9'h000, 4'd0},
        {odh_pkg::OP_LOAD,  8'd6,   8'd200, 8'd0,   PRED,  9'h000, 4'd0},
        {odh_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd6,   PRED,  9'h000, 4'd0}, // read behind write
        {odh_pkg::OP_LOAD,  8'd255, 8'd0,   8'd0,   PRED,  9'h000, 4'd0},
        {odh_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd255, TYPED, 9'h000, 4'd0},
        {odh_pkg::OP_LOAD,  8'd255, 8'd255, 8'd0,   PRED,  9'h000, 4'd0},
        {odh_pkg::OP_PIXEL, 8'd0,   8'd0,   8'd255, TYPED, 9'h1FF, 4'd9}
    };

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    odh_pkg::odh_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    odh_pkg::odh_out_t m_data;
    logic              cfg_we;
    logic [1:0]        cfg_wdata;

    // predictor state
    logic [7:0]        gamma_copy [odh_pkg::TABLE_DEPTH];
    bit                loaded [odh_pkg::TABLE_DEPTH];
    logic [1:0]        size_reg = 2'd3;
    odh_pkg::odh_out_t expected_dots [$];
    odh_pkg::odh_out_t oldest;
    logic              cur_typed = 1'b0;
    odh_pkg::odh_out_t cur_want = '0;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned errors = 0;

    always #5 aclk = ~aclk;

    ordered_dither_halftone_block #(.MAX_BLOCK(MAX_BLOCK)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    function automatic odh_pkg::odh_out_t halftone_of(input logic [7:0] pix);
        int m;
        int step;
        int lvl;
        odh_pkg::odh_out_t r;
        m = (size_reg == 2'd0) ? 1 : int'(size_reg);
        if (m > MAX_BLOCK) m = MAX_BLOCK;
        step = 256 / (m * m);
        lvl = int'(gamma_copy[pix]) / step;
        r = '0;
        for (int row = 0; row < m; row++)
            for (int col = 0; col < m; col++)
                if (lvl > int'(DOT_ORDER[row*3+col])) r.dot_mask[row*3+col] = 1'b1;
        r.level = lvl[3:0];
        return r;
    endfunction

    // Mostly pixels on loaded entries; a pixel on an unloaded entry becomes its load.
    function automatic odh_pkg::odh_in_t random_item();
        odh_pkg::odh_in_t it;
        it.table_index = 8'($urandom_range(255));
        it.pixel = 8'($urandom_range(255));
        case ($urandom_range(7))
            0: it.table_value = 8'd0;
            1: it.table_value = 8'd255;
            default: it.table_value = 8'($urandom_range(255));
        endcase
        it.op = ($urandom_range(99) < 20) ? odh_pkg::OP_LOAD : odh_pkg::OP_PIXEL;
        if (it.op == odh_pkg::OP_PIXEL && !loaded[it.pixel]) begin
            it.op = odh_pkg::OP_LOAD;
            it.table_index = it.pixel;
        end
        return it;
    endfunction

    // predict on input acceptance, check on output acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            if (s_data.op == odh_pkg::OP_LOAD)
                gamma_copy[s_data.table_index] = s_data.table_value;
            else
                expected_dots.push_back(cur_typed ? cur_want : halftone_of(s_data.pixel));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_dots.size() == 0) begin
                $error("result with no pixel outstanding: dot_mask %h level %0d",
                       m_data.dot_mask, m_data.level);
                errors++;
            end else begin
                oldest = expected_dots.pop_front();
                if (m_data.dot_mask !== oldest.dot_mask) begin
                    $error("dot_mask mismatch: expected %h, got %h",
                           oldest.dot_mask, m_data.dot_mask);
                    errors++;
                end
                if (m_data.level !== oldest.level) begin
                    $error("level mismatch: expected %0d, got %0d", oldest.level, m_data.level);
                    errors++;
                end
            end
        end
    end

    // result side: random stalls plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic offer(input odh_pkg::odh_in_t it, input logic typed,
                         input odh_pkg::odh_out_t want);
        s_data <= it;
        s_valid <= 1'b1;
        cur_typed = typed;
        cur_want = want;
        if (it.op == odh_pkg::OP_LOAD) loaded[it.table_index] = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (expected_dots.size() != 0 && waited < SETTLE_MAX) begin
            @(negedge aclk);
            waited++;
        end
        if (expected_dots.size() != 0) begin
            $error("%0d expected results never arrived", expected_dots.size());
            errors++;
            expected_dots.delete();
        end
        // loads are written on acceptance; pad with idle falling edges after the last result
        repeat (PIPE_TAIL) @(negedge aclk);
    endtask

    task automatic set_block_size(input logic [1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        size_reg = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        odh_pkg::odh_in_t it;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (PLAN[i]) offer(PLAN[i].item, PLAN[i].typed, PLAN[i].want);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            tx_idle_pct = (p < 2) ? 20 : (p < 4) ? 58 : 0;
            rx_idle_pct = (p < 2) ? 58 : (p < 4) ? 20 : 0;
            set_block_size(PHASE_SIZE[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 100 && (p == 1 || p == 3)) hold_req = 1'b1;
                while ($urandom_range(99) < tx_idle_pct) begin
                    s_valid <= 1'b0;
                    @(negedge aclk);
                end
                it = random_item();
                offer(it, PRED, '0);
            end
            // the sender waits out every outstanding result before the next setting
            settle();
        end

        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/odh_pkg.sv
rtl/core/odh_ram.sv
rtl/core/ordered_dither_halftone_block.sv
rtl/core/odh_checker.sv
verif/tb_top.sv
